// File: hw/rtl/quoted_field_tokenizer_defines.svh
// Assertion macros for the field tokenizer.
`ifndef QUOTED_FIELD_TOKENIZER_DEFINES_SVH
`define QUOTED_FIELD_TOKENIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QFT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qft: same-cycle check failed");
`define QFT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qft: next-cycle check failed");
`else
`define QFT_IMPLY(label, ante, cons)
`define QFT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/qft_pkg.sv
package qft_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam logic [1:0] MODE_GAP    = 2'd0;
	localparam logic [1:0] MODE_PLAIN  = 2'd1;
	localparam logic [1:0] MODE_QUOTED = 2'd2;
	localparam logic [1:0] MODE_ESCAPE = 2'd3;

	localparam logic [3:0] FIELD_MAX = 4'd15;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [3:0] field_number;
		logic       field_done;
		logic       line_done;
		logic       run_last;
	} res_t;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
	endfunction

endpackage

// File: hw/rtl/qft_if.sv
interface qft_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       line_last;

	modport source (output valid, output in_byte, output line_last, input ready);
	modport sink (input valid, input in_byte, input line_last, output ready);
endinterface

interface qft_tok_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [3:0] field_number;
	logic       field_done;
	logic       line_done;
	logic       run_last;

	modport source (output valid, output out_byte, output byte_valid, output field_number,
		output field_done, output line_done, output run_last, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input field_number,
		input field_done, input line_done, input run_last, output ready);
endinterface

// File: hw/rtl/quoted_field_tokenizer.sv
// Channel  Role    Payload                                               Transaction
// bytes    sink    in_byte[7:0], line_last                               one character
// tokens   source  out_byte[7:0], byte_valid, field_number[3:0],         one result
//                  field_done, line_done, run_last
// One character per cycle while the result side takes each result; a character
// that yields two results holds the result register until both are taken. Each
// character moves from the input register to the result register. Reset clears
// valid flags, scan mode and field count. A stalled result side holds one
// character in the input register, then drops bytes.ready.
`include "quoted_field_tokenizer_defines.svh"

module quoted_field_tokenizer (
	input  logic          clk,
	input  logic          arst_n,
	qft_byte_if.sink      bytes,
	qft_tok_if.source     tokens
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [1:0]  mode_q;
	logic [3:0]  fc_q;

	qft_pkg::res_t slot0_q;
	qft_pkg::res_t slot1_q;
	logic [1:0]  rem_q;

	logic        load;
	logic        in_acc;
	logic        out_acc;

	logic [1:0]  n;
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic        v0;
	logic        v1;
	logic        fd;
	logic        ldn;
	logic [1:0]  nm;
	logic [3:0]  nfc;
	qft_pkg::res_t r0;
	qft_pkg::res_t r1;

	assign out_acc = tokens.valid && tokens.ready;
	assign load = valid_s1 && ((rem_q == 2'd0) || ((rem_q == 2'd1) && tokens.ready));
	assign bytes.ready = !valid_s1 || load;
	assign in_acc = bytes.valid && bytes.ready;

	always_comb begin
		n   = 2'd0;
		b0  = 8'd0;
		b1  = 8'd0;
		v0  = 1'b0;
		v1  = 1'b0;
		fd  = 1'b0;
		ldn = 1'b0;
		nm  = mode_q;
		case (mode_q)
			qft_pkg::MODE_GAP: begin
				if (qft_pkg::is_sep(byte_s1)) begin
					nm = qft_pkg::MODE_GAP;
				end else if (byte_s1 == qft_pkg::CH_QUOTE) begin
					nm = qft_pkg::MODE_QUOTED;
				end else begin
					b0 = byte_s1;
					v0 = 1'b1;
					n  = 2'd1;
					nm = qft_pkg::MODE_PLAIN;
				end
			end
			qft_pkg::MODE_PLAIN: begin
				if (qft_pkg::is_sep(byte_s1)) begin
					n  = 2'd1;
					fd = 1'b1;
					nm = qft_pkg::MODE_GAP;
				end else begin
					b0 = byte_s1;
					v0 = 1'b1;
					n  = 2'd1;
				end
			end
			qft_pkg::MODE_QUOTED: begin
				if (byte_s1 == qft_pkg::CH_QUOTE) begin
					n  = 2'd1;
					fd = 1'b1;
					nm = qft_pkg::MODE_GAP;
				end else if (byte_s1 == qft_pkg::CH_BSLASH) begin
					nm = qft_pkg::MODE_ESCAPE;
				end else begin
					b0 = byte_s1;
					v0 = 1'b1;
					n  = 2'd1;
				end
			end
			default: begin
				if (byte_s1 != qft_pkg::CH_QUOTE) begin
					b0 = qft_pkg::CH_BSLASH;
					v0 = 1'b1;
					b1 = byte_s1;
					v1 = 1'b1;
					n  = 2'd2;
				end else begin
					b0 = byte_s1;
					v0 = 1'b1;
					n  = 2'd1;
				end
				nm = qft_pkg::MODE_QUOTED;
			end
		endcase

		if (last_s1) begin
			// lone backslash at end of line
			if (nm == qft_pkg::MODE_ESCAPE) begin
				b0 = qft_pkg::CH_BSLASH;
				v0 = 1'b1;
				n  = 2'd1;
				nm = qft_pkg::MODE_QUOTED;
			end
			if ((nm == qft_pkg::MODE_PLAIN) || (nm == qft_pkg::MODE_QUOTED)) begin
				fd = 1'b1;
			end
			if (n == 2'd0) begin
				n = 2'd1;
			end
			ldn = 1'b1;
			nm  = qft_pkg::MODE_GAP;
		end

		if (last_s1) begin
			nfc = 4'd0;
		end else if (fd && (fc_q != qft_pkg::FIELD_MAX)) begin
			nfc = fc_q + 4'd1;
		end else begin
			nfc = fc_q;
		end

		r0.out_byte     = b0;
		r0.byte_valid   = v0;
		r0.field_number = fc_q;
		r0.field_done   = (n == 2'd1) && fd;
		r0.line_done    = (n == 2'd1) && ldn;
		r0.run_last     = (n == 2'd1);

		r1.out_byte     = b1;
		r1.byte_valid   = v1;
		r1.field_number = fc_q;
		r1.field_done   = fd;
		r1.line_done    = ldn;
		r1.run_last     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= bytes.in_byte;
			last_s1 <= bytes.line_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= qft_pkg::MODE_GAP;
			fc_q   <= 4'd0;
		end else if (load) begin
			mode_q <= nm;
			fc_q   <= nfc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load) begin
			rem_q <= n;
		end else if (out_acc) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (out_acc) begin
			// advance second result
			slot0_q <= slot1_q;
		end
	end

	assign tokens.valid        = (rem_q != 2'd0);
	assign tokens.out_byte     = slot0_q.out_byte;
	assign tokens.byte_valid   = slot0_q.byte_valid;
	assign tokens.field_number = slot0_q.field_number;
	assign tokens.field_done   = slot0_q.field_done;
	assign tokens.line_done    = slot0_q.line_done;
	assign tokens.run_last     = slot0_q.run_last;

	`QFT_IMPLY(a_first_of_two, rem_q == 2'd2, !slot0_q.run_last && !slot0_q.line_done)
	`QFT_IMPLY(a_line_done_last, tokens.valid && tokens.line_done, tokens.run_last)
	`QFT_IMPLY(a_empty_byte_zero, tokens.valid && !tokens.byte_valid, tokens.out_byte == 8'd0)
	`QFT_NEXT(a_line_resets, load && last_s1, (fc_q == 4'd0) && (mode_q == qft_pkg::MODE_GAP))
	`QFT_NEXT(a_s1_holds, valid_s1 && !load, valid_s1 && $stable(byte_s1))

endmodule
